// ===== hdl/dha_pkg.sv =====
// shared types, widths and codes of the dense handle allocator
package dha_pkg;

    // handle width is fixed by the 8-bit identifier fields, so the pool is 2**8
    localparam int HANDLE_W    = 8;
    localparam int COUNT_W     = HANDLE_W + 1;
    localparam int MAX_HANDLES = 1 << HANDLE_W;

    typedef logic [1:0]          cmd_t;
    typedef logic [1:0]          status_t;
    typedef logic [HANDLE_W-1:0] handle_t;
    typedef logic [COUNT_W-1:0]  count_t;

    localparam cmd_t CMD_ADD    = 2'd0;
    localparam cmd_t CMD_REMOVE = 2'd1;
    localparam cmd_t CMD_LOOKUP = 2'd2;

    localparam status_t ST_OK       = 2'd0;
    localparam status_t ST_NOT_LIVE = 2'd1;
    localparam status_t ST_FULL     = 2'd2;

    // the position memory holds the free queue and the dense list side by side
    localparam logic REGION_FREE  = 1'b0;
    localparam logic REGION_DENSE = 1'b1;

    localparam count_t COUNT_FULL = count_t'(MAX_HANDLES);

endpackage

// ===== hdl/dha_ram.sv =====
// generic single-write, single-read synchronous ram with registered read data
module dha_ram #(
    parameter int ADDR_W = 8,
    parameter int DATA_W = 8
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [1 << ADDR_W];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/dense_handle_allocator.sv =====
// dense handle allocator: free-id queue, packed live list and slot table
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_ready  cmd, handle
//   rsp      out        rsp_valid/rsp_ready  status, given_handle, slot, live_total
//
// a full add or dead handle is answered from idle; add reads the queue head,
// lookup the slot table; remove reads the slot table and last dense entry
// together, then makes two writes to the shared position memory port.
// one command at a time; a new beat is taken once the sequencer is idle and
// the result register is empty or being drained. reset clears the counters,
// live bits and queue-written bits at once, with no clearing pass.
module dense_handle_allocator (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    input  dha_pkg::cmd_t     cmd,
    input  dha_pkg::handle_t  handle,
    output logic              rsp_valid,
    input  logic              rsp_ready,
    output dha_pkg::status_t  status,
    output dha_pkg::handle_t  given_handle,
    output dha_pkg::handle_t  slot,
    output dha_pkg::count_t   live_total
);
    import dha_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_ADD  = 3'd1;
    localparam logic [2:0] S_REM1 = 3'd2;
    localparam logic [2:0] S_REM2 = 3'd3;
    localparam logic [2:0] S_LOOK = 3'd4;

    logic [2:0]             state_reg, state_next;
    handle_t                head_reg, head_next;
    handle_t                tail_reg, tail_next;
    count_t                 count_reg, count_next;
    logic [MAX_HANDLES-1:0] live_reg, live_next;
    logic [MAX_HANDLES-1:0] fq_written_reg, fq_written_next;
    handle_t                h_reg, h_next;
    handle_t                s_reg, s_next;

    logic     rsp_valid_reg, rsp_valid_next;
    status_t  status_reg, status_next;
    handle_t  given_reg, given_next;
    handle_t  slot_reg, slot_next;
    count_t   total_reg, total_next;

    logic              pos_we, pos_re;
    logic [HANDLE_W:0] pos_waddr, pos_raddr;
    handle_t           pos_wdata, pos_rdata;
    logic              slot_we, slot_re;
    handle_t           slot_waddr, slot_raddr, slot_wdata, slot_rdata;

    logic    in_beat;
    handle_t new_id;
    handle_t last_pos;
    count_t  count_inc, count_dec;

    dha_ram #(.ADDR_W(HANDLE_W + 1), .DATA_W(HANDLE_W)) u_pos_ram (
        .clk   (clk),
        .we    (pos_we),
        .waddr (pos_waddr),
        .wdata (pos_wdata),
        .re    (pos_re),
        .raddr (pos_raddr),
        .rdata (pos_rdata)
    );

    dha_ram #(.ADDR_W(HANDLE_W), .DATA_W(HANDLE_W)) u_slot_ram (
        .clk   (clk),
        .we    (slot_we),
        .waddr (slot_waddr),
        .wdata (slot_wdata),
        .re    (slot_re),
        .raddr (slot_raddr),
        .rdata (slot_rdata)
    );

    assign req_ready = (state_reg == S_IDLE) && (!rsp_valid_reg || rsp_ready);
    assign in_beat   = req_valid && req_ready;
    assign count_inc = count_reg + 1'b1;
    assign count_dec = count_reg - 1'b1;
    assign last_pos  = count_dec[HANDLE_W-1:0];

    // queue positions never written give their own index as the identifier
    assign new_id = fq_written_reg[head_reg] ? pos_rdata : head_reg;

    always_comb
    begin
        state_next      = state_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        count_next      = count_reg;
        live_next       = live_reg;
        fq_written_next = fq_written_reg;
        h_next          = h_reg;
        s_next          = s_reg;

        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        status_next    = status_reg;
        given_next     = given_reg;
        slot_next      = slot_reg;
        total_next     = total_reg;

        pos_we     = 1'b0;
        pos_waddr  = {REGION_DENSE, count_reg[HANDLE_W-1:0]};
        pos_wdata  = new_id;
        pos_re     = 1'b0;
        pos_raddr  = {REGION_FREE, head_reg};
        slot_we    = 1'b0;
        slot_waddr = new_id;
        slot_wdata = count_reg[HANDLE_W-1:0];
        slot_re    = 1'b0;
        slot_raddr = handle;

        case (state_reg)
            S_IDLE:
            begin
                if (in_beat)
                begin
                    h_next = handle;
                    if (cmd == CMD_ADD)
                    begin
                        if (count_reg == COUNT_FULL)
                        begin
                            rsp_valid_next = 1'b1;
                            status_next    = ST_FULL;
                            given_next     = '0;
                            slot_next      = '0;
                            total_next     = count_reg;
                        end
                        else
                        begin
                            pos_re     = 1'b1;
                            state_next = S_ADD;
                        end
                    end
                    else if (!live_reg[handle])
                    begin
                        rsp_valid_next = 1'b1;
                        status_next    = ST_NOT_LIVE;
                        given_next     = handle;
                        slot_next      = '0;
                        total_next     = count_reg;
                    end
                    else if (cmd == CMD_REMOVE)
                    begin
                        slot_re    = 1'b1;
                        pos_re     = 1'b1;
                        pos_raddr  = {REGION_DENSE, last_pos};
                        state_next = S_REM1;
                    end
                    else
                    begin
                        // lookup, and the unused selector behaves the same
                        slot_re    = 1'b1;
                        state_next = S_LOOK;
                    end
                end
            end
            S_ADD:
            begin
                pos_we               = 1'b1;
                slot_we              = 1'b1;
                live_next[new_id]    = 1'b1;
                head_next            = head_reg + 1'b1;
                count_next           = count_inc;
                rsp_valid_next       = 1'b1;
                status_next          = ST_OK;
                given_next           = new_id;
                slot_next            = count_reg[HANDLE_W-1:0];
                total_next           = count_inc;
                state_next           = S_IDLE;
            end
            S_REM1:
            begin
                // move the last dense entry into the vacated slot
                pos_we     = 1'b1;
                pos_waddr  = {REGION_DENSE, slot_rdata};
                pos_wdata  = pos_rdata;
                slot_we    = 1'b1;
                slot_waddr = pos_rdata;
                slot_wdata = slot_rdata;
                s_next     = slot_rdata;
                state_next = S_REM2;
            end
            S_REM2:
            begin
                pos_we                    = 1'b1;
                pos_waddr                 = {REGION_FREE, tail_reg};
                pos_wdata                 = h_reg;
                fq_written_next[tail_reg] = 1'b1;
                tail_next                 = tail_reg + 1'b1;
                live_next[h_reg]          = 1'b0;
                count_next                = count_dec;
                rsp_valid_next            = 1'b1;
                status_next               = ST_OK;
                given_next                = h_reg;
                slot_next                 = s_reg;
                total_next                = count_dec;
                state_next                = S_IDLE;
            end
            S_LOOK:
            begin
                rsp_valid_next = 1'b1;
                status_next    = ST_OK;
                given_next     = h_reg;
                slot_next      = slot_rdata;
                total_next     = count_reg;
                state_next     = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            head_reg       <= '0;
            tail_reg       <= '0;
            count_reg      <= '0;
            live_reg       <= '0;
            fq_written_reg <= '0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            head_reg       <= head_next;
            tail_reg       <= tail_next;
            count_reg      <= count_next;
            live_reg       <= live_next;
            fq_written_reg <= fq_written_next;
            rsp_valid_reg  <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        h_reg      <= h_next;
        s_reg      <= s_next;
        status_reg <= status_next;
        given_reg  <= given_next;
        slot_reg   <= slot_next;
        total_reg  <= total_next;
    end

    assign rsp_valid    = rsp_valid_reg;
    assign status       = status_reg;
    assign given_handle = given_reg;
    assign slot         = slot_reg;
    assign live_total   = total_reg;

endmodule

// ===== bench/dense_handle_allocator_tb.sv =====
// self-checking testbench for the dense handle allocator
module dense_handle_allocator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import dha_pkg::*;

    // a selector of three is taken as a lookup
    localparam cmd_t CMD_ALT_LOOKUP = 2'd3;

    typedef struct {
        status_t status;
        handle_t given;
        handle_t slot;
        count_t  total;
    } outcome_t;

    class handle_scoreboard;
        bit       live_bit  [MAX_HANDLES];
        handle_t  slot_rec  [MAX_HANDLES];
        handle_t  dense_pos [MAX_HANDLES];
        handle_t  free_ids  [MAX_HANDLES];
        handle_t  free_rd;
        handle_t  free_wr;
        count_t   live_cnt;
        outcome_t owed_outcomes[$];
        int       errors;

        function new();
            for (int i = 0; i < MAX_HANDLES; i++)
            begin
                free_ids[i]  = handle_t'(i);
                live_bit[i]  = 1'b0;
                slot_rec[i]  = '0;
                dense_pos[i] = '0;
            end
            free_rd  = '0;
            free_wr  = '0;
            live_cnt = '0;
            errors   = 0;
        endfunction

        function int pending();
            return owed_outcomes.size();
        endfunction

        function handle_t any_live();
            return dense_pos[$urandom_range(0, int'(live_cnt) - 1)];
        endfunction

        // applies one accepted request beat to the shadow state
        function void note_request(cmd_t c, handle_t h);
            outcome_t o;
            handle_t  s;
            handle_t  id;
            handle_t  moved;
            o.status = ST_OK;
            o.given  = h;
            o.slot   = '0;
            if (c == CMD_ADD)
            begin
                if (live_cnt == COUNT_FULL)
                begin
                    o.status = ST_FULL;
                    o.given  = '0;
                end
                else
                begin
                    s  = handle_t'(live_cnt);
                    id = free_ids[free_rd];
                    free_rd++;
                    dense_pos[s] = id;
                    slot_rec[id] = s;
                    live_bit[id] = 1'b1;
                    live_cnt++;
                    o.given = id;
                    o.slot  = s;
                end
            end
            else if (!live_bit[h])
            begin
                o.status = ST_NOT_LIVE;
            end
            else if (c == CMD_REMOVE)
            begin
                // last entry fills the hole; if h was last this is a no-op move
                s     = slot_rec[h];
                moved = dense_pos[live_cnt - 1];
                dense_pos[s]    = moved;
                slot_rec[moved] = s;
                live_bit[h]     = 1'b0;
                free_ids[free_wr] = h;
                free_wr++;
                live_cnt--;
                o.slot = s;
            end
            else
            begin
                o.slot = slot_rec[h];
            end
            o.total = live_cnt;
            owed_outcomes.push_back(o);
        endfunction

        task report_mismatch(string field, int got, int want);
            $display("%0t ns: mismatch on %s: got %0d, want %0d", $time, field, got, want);
            errors++;
        endtask

        task check_result(status_t st, handle_t g, handle_t sl, count_t tot);
            outcome_t o;
            if (owed_outcomes.size() == 0)
            begin
                report_mismatch("beat with nothing owed", int'(g), 0);
                return;
            end
            o = owed_outcomes.pop_front();
            if (st !== o.status)
                report_mismatch("status", int'(st), int'(o.status));
            if (g !== o.given)
                report_mismatch("given_handle", int'(g), int'(o.given));
            if (sl !== o.slot)
                report_mismatch("slot", int'(sl), int'(o.slot));
            if (tot !== o.total)
                report_mismatch("live_total", int'(tot), int'(o.total));
        endtask
    endclass

    logic    clk;
    logic    rst_n;
    logic    req_valid;
    logic    req_ready;
    cmd_t    cmd;
    handle_t handle;
    logic    rsp_valid;
    logic    rsp_ready;
    status_t status;
    handle_t given_handle;
    handle_t slot;
    count_t  live_total;

    handle_scoreboard book;
    bit hold_wanted = 1'b0;
    bit hold_taken  = 1'b0;

    dense_handle_allocator uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .req_valid    (req_valid),
        .req_ready    (req_ready),
        .cmd          (cmd),
        .handle       (handle),
        .rsp_valid    (rsp_valid),
        .rsp_ready    (rsp_ready),
        .status       (status),
        .given_handle (given_handle),
        .slot         (slot),
        .live_total   (live_total)
    );

    initial clk = 1'b0;
    always #1 clk = ~clk;

    // called at a rising edge; returns at the edge that accepts the beat
    task automatic send_beat(cmd_t c, handle_t h, bit calm);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 7);
        if (gap != 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        cmd       <= c;
        handle    <= h;
        do @(posedge clk); while (!req_ready);
        book.note_request(c, h);
    endtask

    initial
    begin
        #1ms;
        $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        int   add_pct [5];
        int   phase_len [5];
        int   roll;
        int   sent;
        cmd_t c;
        handle_t h;
        add_pct   = '{95, 50, 8, 50, 85};
        phase_len = '{320, 200, 300, 150, 160};
        sent      = 0;
        book      = new();
        rst_n     = 1'b0;
        req_valid = 1'b0;
        cmd       = CMD_ADD;
        handle    = '0;
        rsp_ready = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        fork
            begin : result_side
                int stall;
                int seen;
                seen = 0;
                forever
                begin
                    if (hold_wanted && !hold_taken)
                    begin
                        hold_taken = 1'b1;
                        stall = 60;
                    end
                    else
                    begin
                        stall = ((seen % 90) < 25) ? 0 : $urandom_range(0, 7);
                    end
                    if (stall != 0)
                    begin
                        rsp_ready <= 1'b0;
                        repeat (stall) @(posedge clk);
                    end
                    rsp_ready <= 1'b1;
                    do @(posedge clk); while (!rsp_valid);
                    book.check_result(status, given_handle, slot, live_total);
                    seen++;
                end
            end
        join_none

        // dead handles, selector three, adds in queue order, removes of the
        // middle and the last entry, adds after removes, drain to empty
        send_beat(CMD_LOOKUP, 8'd0, 1'b0);
        send_beat(CMD_REMOVE, 8'd255, 1'b0);
        send_beat(CMD_ALT_LOOKUP, 8'hAA, 1'b1);
        send_beat(CMD_ADD, 8'hFF, 1'b1);
        send_beat(CMD_ADD, 8'h00, 1'b0);
        send_beat(CMD_ADD, 8'h55, 1'b1);
        send_beat(CMD_ADD, 8'hAA, 1'b0);
        send_beat(CMD_LOOKUP, 8'd2, 1'b1);
        send_beat(CMD_ALT_LOOKUP, 8'd1, 1'b0);
        send_beat(CMD_REMOVE, 8'd1, 1'b1);
        send_beat(CMD_LOOKUP, 8'd3, 1'b1);
        send_beat(CMD_REMOVE, 8'd2, 1'b0);
        send_beat(CMD_LOOKUP, 8'd2, 1'b1);
        send_beat(CMD_REMOVE, 8'd2, 1'b0);
        send_beat(CMD_ADD, 8'h00, 1'b1);
        send_beat(CMD_REMOVE, 8'd0, 1'b0);
        send_beat(CMD_LOOKUP, 8'h55, 1'b1);
        send_beat(CMD_REMOVE, 8'd3, 1'b0);
        send_beat(CMD_REMOVE, 8'd4, 1'b1);
        send_beat(CMD_ADD, 8'h00, 1'b0);
        send_beat(CMD_REMOVE, 8'd5, 1'b1);

        // phases swing the pool from empty to full (and past it) and back
        for (int p = 0; p < 5; p++)
        begin
            for (int k = 0; k < phase_len[p]; k++)
            begin
                roll = $urandom_range(0, 99);
                if (roll < add_pct[p])
                begin
                    c = CMD_ADD;
                end
                else
                begin
                    roll = $urandom_range(0, 9);
                    c = (roll < 6) ? CMD_REMOVE : (roll < 9) ? CMD_LOOKUP : CMD_ALT_LOOKUP;
                end
                if (book.live_cnt != 0 && $urandom_range(0, 99) < 85)
                    h = book.any_live();
                else
                    h = handle_t'($urandom_range(0, 255));
                send_beat(c, h, (k % 100) < 30);
                sent++;
                if (sent == 500)
                    hold_wanted = 1'b1;
            end
        end
        req_valid <= 1'b0;

        while (book.pending() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
        if (book.errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule
